### rtl/lcbc_pkg.sv
// ----------------------------------------------------------------------------
// lcbc_pkg
// Shared types and constants for the Luhn check / card brand unit.
// ----------------------------------------------------------------------------
package lcbc_pkg;

    localparam int IN_WIDTH        = 54;
    localparam int IN_TDATA_WIDTH  = ((IN_WIDTH + 7) / 8) * 8;
    localparam int BCD_DIGITS      = 17;                  // 2^54-1 has 17 digits
    localparam int BCD_WIDTH       = 4 * BCD_DIGITS;
    localparam int BITS_PER_STEP   = 3;
    localparam int CONV_STEPS      = IN_WIDTH / BITS_PER_STEP;
    localparam int CONV_CNT_WIDTH  = $clog2(CONV_STEPS);
    localparam int COUNT_WIDTH     = 5;
    localparam int MAX_DIGITS      = 16;
    localparam int OUT_WIDTH       = 12;
    localparam int OUT_TDATA_WIDTH = ((OUT_WIDTH + 7) / 8) * 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SCAN
    } state_t;

    typedef enum logic [1:0] {
        BRAND_INVALID    = 2'd0,
        BRAND_AMEX       = 2'd1,
        BRAND_VISA       = 2'd2,
        BRAND_MASTERCARD = 2'd3
    } brand_t;

    // packed MSB first: brand ends up in the lowest bits
    typedef struct packed {
        logic [COUNT_WIDTH-1:0] digit_count;
        logic [3:0]             sum_mod_ten;
        logic                   luhn_ok;
        brand_t                 brand;
    } result_t;

endpackage

### rtl/luhn_card_brand_check_unit.sv
// ----------------------------------------------------------------------------
// luhn_card_brand_check_unit
// Luhn mod-10 check, digit count and card brand of a binary card number.
// ----------------------------------------------------------------------------
// One item is a binary card number; the result is its brand, the Luhn pass
// flag, the Luhn sum modulo 10 and the decimal digit count (0 to 17). The
// accepting edge loads the number; the binary-to-BCD converter (a shift/add-3
// unit that takes 3 input bits per cycle) runs first, then one shared digit
// adder peels a digit per cycle and updates the running sum, and at last the
// result is registered. The input side is ready again once the result is
// registered, so the unit takes no new number before it is through with the
// last one. A finished result waits in its output register without blocking
// the next item, but a scan that ends while that register is still full holds
// until it drains. Numbers longer than MAX_DIGITS (16 by default) are
// reported with luhn_ok low and brand INVALID.
module luhn_card_brand_check_unit
#(
    parameter int MAX_DIGITS = lcbc_pkg::MAX_DIGITS
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [lcbc_pkg::IN_TDATA_WIDTH-1:0]   s_tdata,   // [53:0] card_number
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [lcbc_pkg::OUT_TDATA_WIDTH-1:0]  m_tdata    // [1:0] brand, [2] luhn_ok,
                                                             // [6:3] sum_mod_ten,
                                                             // [11:7] digit_count
);

    import lcbc_pkg::*;

    state_t                    state_reg, state_next;
    logic [IN_WIDTH-1:0]       bin_reg, bin_next;
    logic [BCD_WIDTH-1:0]      bcd_reg, bcd_next;
    logic [CONV_CNT_WIDTH-1:0] conv_cnt_reg, conv_cnt_next;
    logic [COUNT_WIDTH-1:0]    count_reg, count_next;
    logic [3:0]                sum_reg, sum_next;
    logic [3:0]                top_reg, top_next;
    logic [3:0]                second_reg, second_next;
    result_t                   result_reg, result_next;
    logic                      out_valid_reg, out_valid_next;

    logic                      in_accept;
    logic                      scan_done;
    logic                      load_out;
    logic [BCD_WIDTH-1:0]      bcd_conv;
    logic [3:0]                digit;
    logic [3:0]                contrib;
    logic [4:0]                sum_raw;
    logic                      ok;
    brand_t                    brand;

    // one double-dabble step: add 3 to every digit >= 5, then shift in a bit
    function automatic logic [BCD_WIDTH-1:0] dabble_step(input logic [BCD_WIDTH-1:0] bcd,
                                                         input logic bit_in);
        logic [BCD_WIDTH-1:0] adj;
        adj = bcd;
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            if (adj[4*i +: 4] >= 4'd5)
            begin
                adj[4*i +: 4] = adj[4*i +: 4] + 4'd3;
            end
        end
        return {adj[BCD_WIDTH-2:0], bit_in};
    endfunction

    // digit sum of 2*d
    function automatic logic [3:0] doubled_digit(input logic [3:0] d);
        logic [3:0] r;
        unique case (d)
            4'd0:    r = 4'd0;
            4'd1:    r = 4'd2;
            4'd2:    r = 4'd4;
            4'd3:    r = 4'd6;
            4'd4:    r = 4'd8;
            4'd5:    r = 4'd1;
            4'd6:    r = 4'd3;
            4'd7:    r = 4'd5;
            4'd8:    r = 4'd7;
            4'd9:    r = 4'd9;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

    always_comb
    begin
        bcd_conv = bcd_reg;
        for (int j = 0; j < BITS_PER_STEP; j++)
        begin
            bcd_conv = dabble_step(bcd_conv, bin_reg[IN_WIDTH-1-j]);
        end
    end

    // digit peel and mod-10 accumulate
    always_comb
    begin
        digit   = bcd_reg[3:0];
        contrib = count_reg[0] ? doubled_digit(digit) : digit;
        sum_raw = {1'b0, sum_reg} + {1'b0, contrib};
        if (sum_raw >= 5'd10)
        begin
            sum_raw = sum_raw - 5'd10;
        end
    end

    // classification of the finished scan
    always_comb
    begin
        ok    = (sum_reg == 4'd0) && (count_reg <= COUNT_WIDTH'(MAX_DIGITS));
        brand = BRAND_INVALID;
        if (ok && count_reg >= 5'd2)
        begin
            priority if (top_reg == 4'd3 && (second_reg == 4'd4 || second_reg == 4'd7)
                         && count_reg == 5'd15)
            begin
                brand = BRAND_AMEX;
            end
            else if (top_reg == 4'd4 && (count_reg == 5'd13 || count_reg == 5'd16))
            begin
                brand = BRAND_VISA;
            end
            else if (top_reg == 4'd5 && second_reg >= 4'd1 && second_reg <= 4'd5
                     && count_reg == 5'd16)
            begin
                brand = BRAND_MASTERCARD;
            end
            else
            begin
                brand = BRAND_INVALID;
            end
        end
    end

    // handshake and control outputs
    always_comb
    begin
        s_tready  = (state_reg == ST_IDLE);
        in_accept = s_tvalid && s_tready;
        scan_done = (state_reg == ST_SCAN) && (bcd_reg == '0);
        load_out  = scan_done && (!out_valid_reg || m_tready);
        m_tvalid  = out_valid_reg;
        m_tdata   = {{(OUT_TDATA_WIDTH-OUT_WIDTH){1'b0}}, result_reg};
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                if (conv_cnt_reg == CONV_CNT_WIDTH'(CONV_STEPS - 1))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        bin_next       = bin_reg;
        bcd_next       = bcd_reg;
        conv_cnt_next  = conv_cnt_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        top_next       = top_reg;
        second_next    = second_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg;

        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    bin_next      = s_tdata[IN_WIDTH-1:0];
                    bcd_next      = '0;
                    conv_cnt_next = '0;
                    count_next    = '0;
                    sum_next      = '0;
                    top_next      = '0;
                    second_next   = '0;
                end
            end
            ST_CONVERT:
            begin
                bin_next      = {bin_reg[IN_WIDTH-BITS_PER_STEP-1:0], {BITS_PER_STEP{1'b0}}};
                bcd_next      = bcd_conv;
                conv_cnt_next = conv_cnt_reg + 1'b1;
            end
            ST_SCAN:
            begin
                if (!scan_done)
                begin
                    bcd_next    = {4'd0, bcd_reg[BCD_WIDTH-1:4]};
                    count_next  = count_reg + 1'b1;
                    sum_next    = sum_raw[3:0];
                    second_next = top_reg;
                    top_next    = digit;
                end
                else if (load_out)
                begin
                    result_next.brand       = brand;
                    result_next.luhn_ok     = ok;
                    result_next.sum_mod_ten = sum_reg;
                    result_next.digit_count = count_reg;
                    out_valid_next          = 1'b1;
                end
            end
            default:
            begin
                bin_next = bin_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg      <= bin_next;
        bcd_reg      <= bcd_next;
        conv_cnt_reg <= conv_cnt_next;
        count_reg    <= count_next;
        sum_reg      <= sum_next;
        top_reg      <= top_next;
        second_reg   <= second_next;
        result_reg   <= result_next;
    end

    // a branded result always passed Luhn and has a brand length
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && result_reg.brand != BRAND_INVALID |->
            result_reg.luhn_ok && (result_reg.digit_count == 5'd13 ||
            result_reg.digit_count == 5'd15 || result_reg.digit_count == 5'd16))
        else $error("branded result without Luhn pass or valid length");

    // an accepted item starts conversion and blocks further input
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> state_reg == ST_CONVERT && !s_tready)
        else $error("accepted item did not start conversion");

    // running sum stays reduced modulo 10 during the scan
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SCAN && $past(state_reg) == ST_SCAN |-> sum_reg < 4'd10)
        else $error("running Luhn sum out of range");

    // converter step count stays inside the conversion window
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CONVERT |-> conv_cnt_reg < CONV_CNT_WIDTH'(CONV_STEPS))
        else $error("conversion step counter overran");

endmodule
